### rtl/mmc_pkg.sv
// Shared types, codes and reset values for the motion mode classifier.
`default_nettype none

package mmc_pkg;

    // Channel widths.
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Mode codes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LIFT = 2'd1;
    localparam logic [1:0] MODE_SKI  = 2'd2;

    // Activity kinds that carry meaning.
    localparam logic [3:0] KIND_IN_VEHICLE = 4'd0;
    localparam logic [3:0] KIND_STILL      = 4'd3;

    // Item opcodes.
    localparam logic OP_HINT   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_CLIMB    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKI_DESCENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKI_SPEED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEHICLE_CLIMB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_CONF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CONSIST_LIMIT = 3'd6;

    // Configuration reset values.
    localparam logic signed [15:0] RST_LIFT_CLIMB    = 16'sd205;
    localparam logic signed [15:0] RST_SKI_DESCENT   = -16'sd205;
    localparam logic [15:0]        RST_SKI_SPEED     = 16'd1024;
    localparam logic [15:0]        RST_IDLE_SPEED    = 16'd205;
    localparam logic signed [15:0] RST_VEHICLE_CLIMB = 16'sd51;
    localparam logic [6:0]         RST_STRONG_CONF   = 7'd70;
    localparam logic [7:0]         RST_CONSIST_LIMIT = 8'd5;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic signed [15:0] lift_climb_rate;
        logic signed [15:0] ski_drop_rate;
        logic [15:0]        ski_speed;
        logic [15:0]        idle_speed;
        logic signed [15:0] vehicle_climb_rate;
        logic [6:0]         strong_confidence;
        logic [7:0]         consistency_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] lift_count;
        logic [7:0] ski_count;
        logic [7:0] idle_count;
        logic [3:0] hint_kind;
        logic [6:0] hint_confidence;
    } state_t;

endpackage

`default_nettype wire

### rtl/mmc_cfg_regs.sv
// Configuration register file of the motion mode classifier.
`default_nettype none

module mmc_cfg_regs
    import mmc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index; indexes beyond the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_LIFT_CLIMB:    cfg_next.lift_climb_rate    = $signed(wr_data);
                REG_SKI_DESCENT:   cfg_next.ski_drop_rate      = $signed(wr_data);
                REG_SKI_SPEED:     cfg_next.ski_speed          = wr_data;
                REG_IDLE_SPEED:    cfg_next.idle_speed         = wr_data;
                REG_VEHICLE_CLIMB: cfg_next.vehicle_climb_rate = $signed(wr_data);
                REG_STRONG_CONF:   cfg_next.strong_confidence  = wr_data[6:0];
                REG_CONSIST_LIMIT: cfg_next.consistency_limit  = wr_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lift_climb_rate    <= RST_LIFT_CLIMB;
            cfg_reg.ski_drop_rate      <= RST_SKI_DESCENT;
            cfg_reg.ski_speed          <= RST_SKI_SPEED;
            cfg_reg.idle_speed         <= RST_IDLE_SPEED;
            cfg_reg.vehicle_climb_rate <= RST_VEHICLE_CLIMB;
            cfg_reg.strong_confidence  <= RST_STRONG_CONF;
            cfg_reg.consistency_limit  <= RST_CONSIST_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/mmc_decide.sv
// Classification and counter update logic for one hint or motion sample.
`default_nettype none

module mmc_decide
    import mmc_pkg::*;
(
    input  wire cfg_t               cfg,
    input  wire state_t             st,
    input  wire logic               opcode,
    input  wire logic [15:0]        speed,
    input  wire logic signed [15:0] vertical_velocity,
    input  wire logic [3:0]         activity_kind,
    input  wire logic [6:0]         activity_confidence,
    output state_t                  st_next,
    output logic [1:0]              desired_mode
);

    // Saturating rise by one, or by two when the hint agrees.
    function automatic logic [7:0] cnt_rise(input logic [7:0] c, input logic twice);
        logic [8:0] sum;
        sum = {1'b0, c} + (twice ? 9'd2 : 9'd1);
        return sum[8] ? COUNT_MAX : sum[7:0];
    endfunction

    // Fall by one, stopping at zero.
    function automatic logic [7:0] cnt_fall(input logic [7:0] c);
        return (c == 8'd0) ? 8'd0 : c - 8'd1;
    endfunction

    logic hint_strong, in_vehicle, still;
    logic lift_hit, ski_hit, idle_hit;
    logic [7:0] lift_new, ski_new, idle_new;

    // Threshold tests, with the stored hint folded in.
    always_comb begin
        hint_strong = st.hint_confidence > cfg.strong_confidence;
        in_vehicle  = hint_strong && (st.hint_kind == KIND_IN_VEHICLE);
        still       = hint_strong && (st.hint_kind == KIND_STILL);

        lift_hit = (vertical_velocity > cfg.lift_climb_rate)
                 || (in_vehicle && (vertical_velocity > cfg.vehicle_climb_rate));
        ski_hit  = (vertical_velocity < cfg.ski_drop_rate) || (speed > cfg.ski_speed);
        idle_hit = (speed < cfg.idle_speed) || still;

        if (lift_hit && !idle_hit) begin
            desired_mode = MODE_LIFT;
        end else if (ski_hit && !idle_hit) begin
            desired_mode = MODE_SKI;
        end else if (idle_hit) begin
            desired_mode = MODE_IDLE;
        end else begin
            desired_mode = st.mode;
        end
    end

    // Consistency counters follow the desired mode; anything not lift or
    // skiing counts as idle.
    always_comb begin
        if (desired_mode == MODE_LIFT) begin
            lift_new = cnt_rise(st.lift_count, in_vehicle);
            ski_new  = cnt_fall(st.ski_count);
            idle_new = cnt_fall(st.idle_count);
        end else if (desired_mode == MODE_SKI) begin
            lift_new = cnt_fall(st.lift_count);
            ski_new  = cnt_rise(st.ski_count, 1'b0);
            idle_new = cnt_fall(st.idle_count);
        end else begin
            lift_new = cnt_fall(st.lift_count);
            ski_new  = cnt_fall(st.ski_count);
            idle_new = cnt_rise(st.idle_count, still);
        end
    end

    // Next state: a hint only replaces the stored hint, a sample moves the
    // counters and possibly the mode.
    always_comb begin
        st_next = st;
        if (opcode == OP_HINT) begin
            st_next.hint_kind       = activity_kind;
            st_next.hint_confidence = activity_confidence;
        end else begin
            st_next.lift_count = lift_new;
            st_next.ski_count  = ski_new;
            st_next.idle_count = idle_new;
            if (lift_new > cfg.consistency_limit) begin
                st_next.mode = MODE_LIFT;
            end else if (ski_new > cfg.consistency_limit) begin
                st_next.mode = MODE_SKI;
            end else if (idle_new > cfg.consistency_limit) begin
                st_next.mode = MODE_IDLE;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/motion_mode_classifier_core.sv
// A motion sample's result passes through the input register and then the result register,
// and is offered once the result register is free; a waiting result can hold it back.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being drained, and hints never wait for it.
// Reset: synchronous, active low; clears mode, counters, hint, valid flags and
// loads the configuration registers with their default thresholds.
`default_nettype none

module motion_mode_classifier_core
    import mmc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] speed, [31:16] vertical_velocity, [35:32] activity_kind,
    // [42:36] activity_confidence, [47:43] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                  s_tuser,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] mode, [3:2] desired_mode, [7:4] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg;
    state_t state_reg;
    state_t state_next;

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [15:0]        in_speed_reg;
    logic signed [15:0] in_vv_reg;
    logic [3:0]         in_kind_reg;
    logic [6:0]         in_conf_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         out_mode_reg;
    logic [1:0]         out_desired_reg;
    logic [1:0]         desired;

    logic advance;
    logic in_xfer;

    assign cfg_ready = 1'b1;

    mmc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mmc_decide u_decide (
        .cfg                 (cfg),
        .st                  (state_reg),
        .opcode              (in_op_reg),
        .speed               (in_speed_reg),
        .vertical_velocity   (in_vv_reg),
        .activity_kind       (in_kind_reg),
        .activity_confidence (in_conf_reg),
        .st_next             (state_next),
        .desired_mode        (desired)
    );

    // The held item moves on when it needs no result slot or the slot frees up.
    assign advance  = in_valid_reg
                    && ((in_op_reg == OP_HINT) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        if (advance && (in_op_reg == OP_SAMPLE)) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_op_reg    <= s_tuser;
            in_speed_reg <= s_tdata[15:0];
            in_vv_reg    <= $signed(s_tdata[31:16]);
            in_kind_reg  <= s_tdata[35:32];
            in_conf_reg  <= s_tdata[42:36];
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance && (in_op_reg == OP_SAMPLE)) begin
            out_mode_reg    <= state_next.mode;
            out_desired_reg <= desired;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_desired_reg, out_mode_reg};

`ifndef ASSERT_OFF
    // A sample that moves on leaves a result showing the updated mode.
    a_sample_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == OP_SAMPLE))
        |=> (m_tvalid && (m_tdata[1:0] == state_reg.mode)))
        else $error("sample transfer did not load a matching result");

    // A hint never disturbs the counters or the mode.
    a_hint_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == OP_HINT))
        |=> ($stable(state_reg.lift_count) && $stable(state_reg.ski_count)
             && $stable(state_reg.idle_count) && $stable(state_reg.mode)))
        else $error("hint changed classifier counters");

    // The lift counter climbs by at most two per sample.
    a_lift_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ({1'b0, state_reg.lift_count}
                     <= ({1'b0, $past(state_reg.lift_count)} + 9'd2)))
        else $error("lift counter rose too fast");

    // The input register is never overwritten while it holds a waiting item.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_tready)
        else $error("input register overrun");
`endif

endmodule

`default_nettype wire

### dv/motion_mode_classifier_core_tb.sv
// Self-checking testbench for the motion mode classifier core, with a predictor and scoreboard.
`timescale 1ns / 100ps

module motion_mode_classifier_core_tb
    import mmc_pkg::*;
();

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Cycles the receiver holds off to back up the block.
    localparam int HOLD_CYCLES = 200;

    // One expected result: mode after the sample and the mode it suggested.
    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] desired;
    } mode_result_t;

    // Tracks the classifier state, predicts results and checks them in order.
    class mode_scoreboard;
        cfg_t         thresholds;
        logic [1:0]   mode;
        logic [7:0]   lift_cnt;
        logic [7:0]   ski_cnt;
        logic [7:0]   idle_cnt;
        logic [3:0]   hint_kind;
        logic [6:0]   hint_conf;
        mode_result_t expected_modes[$];
        int           mismatch_count;

        function new();
            thresholds.lift_climb_rate    = RST_LIFT_CLIMB;
            thresholds.ski_drop_rate      = RST_SKI_DESCENT;
            thresholds.ski_speed          = RST_SKI_SPEED;
            thresholds.idle_speed         = RST_IDLE_SPEED;
            thresholds.vehicle_climb_rate = RST_VEHICLE_CLIMB;
            thresholds.strong_confidence  = RST_STRONG_CONF;
            thresholds.consistency_limit  = RST_CONSIST_LIMIT;
            mode           = MODE_IDLE;
            lift_cnt       = '0;
            ski_cnt        = '0;
            idle_cnt       = '0;
            hint_kind      = '0;
            hint_conf      = '0;
            mismatch_count = 0;
        endfunction

        function logic [7:0] count_up(logic [7:0] c);
            return (c == COUNT_MAX) ? c : c + 8'd1;
        endfunction

        function logic [7:0] count_down(logic [7:0] c);
            return (c == 8'd0) ? c : c - 8'd1;
        endfunction

        // Mirror one accepted register write.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LIFT_CLIMB:    thresholds.lift_climb_rate    = data;
                REG_SKI_DESCENT:   thresholds.ski_drop_rate      = data;
                REG_SKI_SPEED:     thresholds.ski_speed          = data;
                REG_IDLE_SPEED:    thresholds.idle_speed         = data;
                REG_VEHICLE_CLIMB: thresholds.vehicle_climb_rate = data;
                REG_STRONG_CONF:   thresholds.strong_confidence  = data[6:0];
                REG_CONSIST_LIMIT: thresholds.consistency_limit  = data[7:0];
                default: ;
            endcase
        endfunction

        // Update the state for one accepted item and queue the result it causes.
        function void note_input(logic op, logic [IN_DATA_W-1:0] data);
            logic [15:0]        spd;
            logic signed [15:0] vv;
            logic               hint_strong, in_vehicle, still;
            logic               lift_hit, ski_hit, idle_hit;
            logic [1:0]         desired;
            mode_result_t       res;

            spd = data[15:0];
            vv  = data[31:16];

            // A hint is only stored.
            if (op == OP_HINT) begin
                hint_kind = data[35:32];
                hint_conf = data[42:36];
                return;
            end

            hint_strong = hint_conf > thresholds.strong_confidence;
            in_vehicle  = hint_strong && (hint_kind == KIND_IN_VEHICLE);
            still       = hint_strong && (hint_kind == KIND_STILL);

            lift_hit = (vv > $signed(thresholds.lift_climb_rate)) ||
                       (in_vehicle && (vv > $signed(thresholds.vehicle_climb_rate)));
            ski_hit  = (vv < $signed(thresholds.ski_drop_rate)) ||
                       (spd > thresholds.ski_speed);
            idle_hit = (spd < thresholds.idle_speed) || still;

            // Idle wins over the others; with nothing likely the mode is kept.
            desired = mode;
            if (lift_hit && !idle_hit) begin
                desired = MODE_LIFT;
            end else if (ski_hit && !idle_hit) begin
                desired = MODE_SKI;
            end else if (idle_hit) begin
                desired = MODE_IDLE;
            end

            // Consistency counters follow the desired mode.
            if (desired == MODE_LIFT) begin
                lift_cnt = count_up(lift_cnt);
                if (in_vehicle) begin
                    lift_cnt = count_up(lift_cnt);
                end
                ski_cnt  = count_down(ski_cnt);
                idle_cnt = count_down(idle_cnt);
            end else if (desired == MODE_SKI) begin
                ski_cnt  = count_up(ski_cnt);
                lift_cnt = count_down(lift_cnt);
                idle_cnt = count_down(idle_cnt);
            end else begin
                idle_cnt = count_up(idle_cnt);
                if (still) begin
                    idle_cnt = count_up(idle_cnt);
                end
                lift_cnt = count_down(lift_cnt);
                ski_cnt  = count_down(ski_cnt);
            end

            // Mode switch, lift first, then skiing, then idle.
            if (lift_cnt > thresholds.consistency_limit) begin
                mode = MODE_LIFT;
            end else if (ski_cnt > thresholds.consistency_limit) begin
                mode = MODE_SKI;
            end else if (idle_cnt > thresholds.consistency_limit) begin
                mode = MODE_IDLE;
            end

            res.mode    = mode;
            res.desired = desired;
            expected_modes.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("ERROR at %0t ns: %s", $time, what);
            mismatch_count++;
        endtask

        // Compare one result transfer with the oldest expectation.
        task check_result(logic [OUT_DATA_W-1:0] data);
            mode_result_t want;

            if (expected_modes.size() == 0) begin
                report_mismatch($sformatf("unexpected result mode=%0d desired=%0d",
                                          data[1:0], data[3:2]));
                return;
            end
            want = expected_modes.pop_front();
            if (data[1:0] !== want.mode) begin
                report_mismatch($sformatf("mode %0d, expected %0d", data[1:0], want.mode));
            end
            if (data[3:2] !== want.desired) begin
                report_mismatch($sformatf("desired_mode %0d, expected %0d",
                                          data[3:2], want.desired));
            end
        endtask

        function int pending();
            return expected_modes.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mode_scoreboard sb;
    int             tx_idle_pct;
    int             rx_stall_pct;
    bit             hold_results;
    int             quiet_cycles = 0;

    motion_mode_classifier_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Receiver readiness, changed at the falling edge.
    always @(negedge aclk) begin
        if (hold_results) begin
            m_tready = 1'b0;
        end else if (rx_stall_pct != 0) begin
            m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
        end else begin
            m_tready = 1'b1;
        end
    end

    // Check results first, then note the input accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser, s_tdata);
            end
        end
    end

    // Watchdog on cycles in which no transfer happens.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one item from a falling edge until its transfer, then apply the sender gap.
    task send_item(logic op, logic [15:0] spd, logic [15:0] vv, logic [3:0] kind,
                   logic [6:0] conf);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {5'b0, conf, kind, vv, spd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge aclk);
        end
    endtask

    task send_sample(logic [15:0] spd, logic [15:0] vv);
        send_item(OP_SAMPLE, spd, vv, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
    endtask

    task send_hint(logic [3:0] kind, logic [6:0] conf);
        send_item(OP_HINT, 16'($urandom), 16'($urandom), kind, conf);
    endtask

    // Register write from a falling edge; the predictor follows at the transfer.
    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task program_thresholds(logic [15:0] lift, logic [15:0] descent, logic [15:0] ski_spd,
                            logic [15:0] idle_spd, logic [15:0] vehicle,
                            logic [6:0] strong_conf, logic [7:0] limit);
        cfg_write(REG_LIFT_CLIMB, lift);
        cfg_write(REG_SKI_DESCENT, descent);
        cfg_write(REG_SKI_SPEED, ski_spd);
        cfg_write(REG_IDLE_SPEED, idle_spd);
        cfg_write(REG_VEHICLE_CLIMB, vehicle);
        cfg_write(REG_STRONG_CONF, {9'b0, strong_conf});
        cfg_write(REG_CONSIST_LIMIT, {8'b0, limit});
    endtask

    // Wait until every expected result has arrived, plus the pipeline depth.
    task wait_results_drained();
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Runs of samples of one kind with hints in between, so counters build up.
    task run_motion_traffic(int n_items);
        int          sent;
        int          run_len;
        int          pick;
        int          roll;
        logic [15:0] spd;
        logic [15:0] vv;
        logic [3:0]  kind;

        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    kind = KIND_IN_VEHICLE;
                end else if (roll < 70) begin
                    kind = KIND_STILL;
                end else begin
                    kind = 4'($urandom_range(0, 15));
                end
                send_hint(kind, 7'($urandom_range(0, 127)));
                sent++;
            end else begin
                pick    = $urandom_range(0, 4);
                run_len = $urandom_range(1, 30);
                if (run_len > n_items - sent) begin
                    run_len = n_items - sent;
                end
                repeat (run_len) begin
                    case (pick)
                        0: begin
                            spd = 16'($urandom_range(206, 1024));
                            vv  = 16'($urandom_range(206, 4000));
                        end
                        1: begin
                            spd = 16'($urandom_range(206, 65535));
                            vv  = 16'(-int'($urandom_range(206, 32768)));
                        end
                        2: begin
                            spd = 16'($urandom_range(0, 204));
                            vv  = 16'($urandom_range(0, 800) - 400);
                        end
                        3: begin
                            spd = 16'($urandom_range(206, 1024));
                            vv  = 16'($urandom_range(0, 408) - 204);
                        end
                        default: begin
                            spd = 16'($urandom);
                            vv  = 16'($urandom);
                        end
                    endcase
                    send_sample(spd, vv);
                    sent++;
                end
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_HINT;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_results = 1'b0;
        sb = new();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed items under the reset thresholds.
        send_sample(16'd0, 16'd0);
        send_sample(16'hFFFF, 16'h8000);
        send_sample(16'd500, 16'h7FFF);
        send_sample(16'd500, 16'd0);
        send_sample(16'd0, 16'h7FFF);
        send_hint(KIND_IN_VEHICLE, 7'd70);
        send_sample(16'd500, 16'd100);
        send_hint(KIND_IN_VEHICLE, 7'd71);
        repeat (3) send_sample(16'd500, 16'd100);
        send_hint(KIND_STILL, 7'd127);
        repeat (3) send_sample(16'hFFFF, 16'h7FFF);
        send_hint(4'd15, 7'd127);
        send_sample(16'hFFFF, 16'h8000);
        send_hint(KIND_IN_VEHICLE, 7'd0);
        send_sample(16'd1024, 16'(-205));
        send_sample(16'd205, 16'd205);
        send_sample(16'd1025, 16'd0);

        // Random phases, each with its own thresholds and handshake pattern.
        for (int ph = 0; ph < 6; ph++) begin
            wait_results_drained();
            case (ph)
                0: program_thresholds(RST_LIFT_CLIMB, RST_SKI_DESCENT, RST_SKI_SPEED,
                                      RST_IDLE_SPEED, RST_VEHICLE_CLIMB, RST_STRONG_CONF,
                                      RST_CONSIST_LIMIT);
                1: program_thresholds(16'($urandom_range(100, 400)),
                                      16'(-int'($urandom_range(100, 400))),
                                      16'($urandom_range(600, 1500)),
                                      16'($urandom_range(100, 300)),
                                      16'($urandom_range(0, 100)), 7'd0, 8'd0);
                2: program_thresholds(16'h7FFF, 16'h8000, 16'hFFFF, 16'd0, 16'h8000,
                                      7'd100, 8'd255);
                3: program_thresholds(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'h7FFF,
                                      7'd0, 8'd254);
                4: program_thresholds(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom),
                                      7'($urandom_range(0, 100)),
                                      8'($urandom_range(0, 12)));
                default: program_thresholds(16'($urandom_range(100, 400)),
                                            16'(-int'($urandom_range(100, 400))),
                                            16'($urandom_range(600, 1500)),
                                            16'($urandom_range(100, 300)),
                                            16'($urandom_range(0, 100)),
                                            7'($urandom_range(40, 90)),
                                            8'($urandom_range(1, 8)));
            endcase

            // Phase order: no idling, sender idle, receiver stalling, both.
            case (ph % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 69;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 69;
                end
                default: begin
                    tx_idle_pct  = 6;
                    rx_stall_pct = 6;
                end
            endcase

            if (ph == 0) begin
                // Receiver holds off while the sender keeps offering items.
                fork
                    begin
                        hold_results = 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_results = 1'b0;
                    end
                join_none
                run_motion_traffic(80);
            end else if (ph == 1) begin
                // Sender pauses mid-phase until all results are in.
                run_motion_traffic(40);
                wait_results_drained();
                run_motion_traffic(40);
            end else if (ph == 2) begin
                // Strong in-vehicle hint drives the lift counter into saturation.
                send_hint(KIND_IN_VEHICLE, 7'd127);
                repeat (140) send_sample(16'($urandom),
                                         16'($urandom_range(0, 65534) - 32767));
                run_motion_traffic(80);
            end else begin
                run_motion_traffic(80);
            end
        end

        // Let the last results come out.
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (sb.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
